[rtl/prime_filter_trial_division_top_assert.svh]
// assertion macros shared by the checker of the prime filter
`ifndef PRIME_FILTER_TRIAL_DIVISION_TOP_ASSERT_SVH
`define PRIME_FILTER_TRIAL_DIVISION_TOP_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define PFTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PFTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/pftd_pkg.sv]
// package of the prime filter: field widths, defaults and shared types
`default_nettype none

package pftd_pkg;

  localparam int NUMBER_W        = 16;
  localparam int COUNT_W         = 7;
  localparam int COUNT_FIELD_MAX = 127;

  localparam int VALUE_BITS_DEF  = 16;
  localparam int MAX_LIST_DEF    = 64;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

`default_nettype wire

[rtl/pftd_if.sv]
// stream interfaces of the prime filter: input and result channels
`default_nettype none

interface pftd_in_if;
  logic                             valid;
  logic                             ready;
  logic [pftd_pkg::NUMBER_W-1:0]    number;
  logic                             end_of_list;

  modport source (output valid, output number, output end_of_list, input ready);
  modport sink   (input valid, input number, input end_of_list, output ready);
endinterface

interface pftd_out_if;
  logic                             valid;
  logic                             ready;
  logic [pftd_pkg::NUMBER_W-1:0]    tested_value;
  logic                             is_prime;
  logic [pftd_pkg::COUNT_W-1:0]     primes_so_far;
  logic                             list_done;

  modport source (output valid, output tested_value, output is_prime,
                  output primes_so_far, output list_done, input ready);
  modport sink   (input valid, input tested_value, input is_prime,
                  input primes_so_far, input list_done, output ready);
endinterface

`default_nettype wire

[rtl/prime_filter_trial_division_top.sv]
// prime filter by trial division: top level with control and result register
//
// in_i carries one value (number) and an end_of_list flag per beat; out_o
// returns one beat per input: the value, is_prime, the running prime count
// of the current list and list_done.
// One item at a time: in_i.ready is high only while no item is in work.
// Values below 2 and even values go from ST_CHECK straight to ST_DONE;
// the next beat is taken once the control is back in ST_IDLE.
// Odd values try odd divisors 3, 5, 7, ... while d*d <= value; each divisor
// costs one pass of the bit-serial remainder unit.
// Worst case for 16-bit values is 127 divisors.
// The result waits in an output register; a new beat is taken while it
// waits, but a finished item holds until the receiver frees that register.
// The prime count saturates at min(MAX_LIST, 127) and clears after the
// beat that carries end_of_list.
// Reset clears the control state and the count; no result is pending.
`default_nettype none

module prime_filter_trial_division_top #(
  parameter int VALUE_BITS = pftd_pkg::VALUE_BITS_DEF,
  parameter int MAX_LIST   = pftd_pkg::MAX_LIST_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pftd_in_if.sink    in_i,
  pftd_out_if.source out_o
);

  localparam int NB  = (VALUE_BITS < pftd_pkg::NUMBER_W) ? VALUE_BITS : pftd_pkg::NUMBER_W;
  localparam int DW  = (NB + 1) / 2 + 2;
  localparam int SQW = NB + 2;
  localparam int CW  = pftd_pkg::COUNT_W;
  localparam logic [CW-1:0] LIMIT =
    CW'((MAX_LIST < pftd_pkg::COUNT_FIELD_MAX) ? MAX_LIST : pftd_pkg::COUNT_FIELD_MAX);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [NB-1:0]  n_q, n_d;
  logic           last_q, last_d;
  logic           prime_q, prime_d;
  logic [DW-1:0]  div_q, div_d;
  logic [SQW-1:0] sq_q, sq_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  count_new;
  logic           ov_q, ov_d;
  logic [pftd_pkg::NUMBER_W-1:0] tv_q, tv_d;
  logic           ip_q, ip_d;
  logic [CW-1:0]  psf_q, psf_d;
  logic           ld_q, ld_d;
  logic           rem_start;
  logic [SQW-1:0] n_ext;
  pftd_pkg::rem_status_t rem_st;

  pftd_rem #(
    .NB(NB),
    .DW(DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (n_q),
    .divisor_i  (div_q),
    .status_o   (rem_st)
  );

  assign n_ext     = SQW'(n_q);
  assign count_new = (prime_q && (count_q < LIMIT)) ? count_q + CW'(1) : count_q;
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    last_d    = last_q;
    prime_d   = prime_q;
    div_d     = div_q;
    sq_d      = sq_q;
    count_d   = count_q;
    ov_d      = ov_q;
    tv_d      = tv_q;
    ip_d      = ip_q;
    psf_d     = psf_q;
    ld_d      = ld_q;
    rem_start = 1'b0;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d     = in_i.number[NB-1:0];
          last_d  = in_i.end_of_list;
          div_d   = DW'(3);
          sq_d    = SQW'(9);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_ext < SQW'(2)) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (n_ext == SQW'(2)) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if (!n_q[0]) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (sq_q > n_ext) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            sq_d    = sq_q + SQW'({div_q, 2'b00}) + SQW'(4);
            div_d   = div_q + DW'(2);
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          tv_d    = pftd_pkg::NUMBER_W'(n_q);
          ip_d    = prime_q;
          psf_d   = count_new;
          ld_d    = last_q;
          count_d = last_q ? '0 : count_new;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    last_q  <= last_d;
    prime_q <= prime_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    tv_q    <= tv_d;
    ip_q    <= ip_d;
    psf_q   <= psf_d;
    ld_q    <= ld_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.tested_value  = tv_q;
  assign out_o.is_prime      = ip_q;
  assign out_o.primes_so_far = psf_q;
  assign out_o.list_done     = ld_q;

endmodule

`default_nettype wire

[rtl/pftd_rem.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module pftd_rem #(
  parameter int NB = 16,
  parameter int DW = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [NB-1:0]         dividend_i,
  input  wire logic [DW-1:0]         divisor_i,
  output pftd_pkg::rem_status_t      status_o
);

  localparam int CW = $clog2(NB + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NB-1:0] sh_q, sh_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   trial;

  assign trial = {rem_q, sh_q[NB-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d = sh_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = DW'(trial);
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

`default_nettype wire

[rtl/pftd_checker.sv]
// port-level checker of the prime filter and its bind to the top level
`default_nettype none

`include "prime_filter_trial_division_top_assert.svh"

module pftd_checker #(
  parameter int MAX_LIST = pftd_pkg::MAX_LIST_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [pftd_pkg::NUMBER_W-1:0] tested_value_i,
  input wire logic                          is_prime_i,
  input wire logic [pftd_pkg::COUNT_W-1:0]  primes_so_far_i
);

  localparam logic [pftd_pkg::COUNT_W-1:0] LIMIT = pftd_pkg::COUNT_W'(
    (MAX_LIST < pftd_pkg::COUNT_FIELD_MAX) ? MAX_LIST : pftd_pkg::COUNT_FIELD_MAX);

  // result beat stays until taken
  `PFTD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped")
  // one item in work at a time
  `PFTD_ASSERT(a_in_busy, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while busy")
  // count never passes its limit
  `PFTD_ASSERT_ALWAYS(a_count_max, !out_valid_i || primes_so_far_i <= LIMIT, "count too big")
  // a prime is 2 or an odd value above 1
  `PFTD_ASSERT(a_prime_val, out_valid_i && is_prime_i |-> (tested_value_i == 2) || (tested_value_i[0] && tested_value_i != 1), "bad prime")
  // a prime result has a nonzero count
  `PFTD_ASSERT(a_prime_cnt, out_valid_i && is_prime_i |-> primes_so_far_i != 0, "prime not counted")

endmodule

bind prime_filter_trial_division_top pftd_checker #(
  .MAX_LIST(MAX_LIST)
) u_pftd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .tested_value_i  (out_o.tested_value),
  .is_prime_i      (out_o.is_prime),
  .primes_so_far_i (out_o.primes_so_far)
);

`default_nettype wire

[bench/tb_prime_filter_trial_division_top.sv]
// testbench of the prime filter: directed table, random lists, scoreboard against a predictor
`timescale 1ns / 100ps

module tb_prime_filter_trial_division_top;

  localparam int COUNT_LIMIT = (pftd_pkg::MAX_LIST_DEF < pftd_pkg::COUNT_FIELD_MAX) ?
                               pftd_pkg::MAX_LIST_DEF : pftd_pkg::COUNT_FIELD_MAX;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2500;
  localparam int N_DIRECTED = 15;

  typedef struct packed {
    logic [pftd_pkg::NUMBER_W-1:0] value;
    logic                          prime;
    logic [pftd_pkg::COUNT_W-1:0]  count;
    logic                          done;
  } prime_result_t;

  typedef struct packed {
    logic [pftd_pkg::NUMBER_W-1:0] number;
    logic                          eol;
    logic                          typed;
    prime_result_t                 res;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pftd_in_if  in_if ();
  pftd_out_if out_if ();

  prime_filter_trial_division_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  prime_result_t  result_fifo [$];
  int unsigned    list_prime_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    mismatches = 0;
  int unsigned    cycles = 0;
  int unsigned    hold_left = 0;
  bit             hold_request;

  // extremes, small primes and composites, square of a prime, list ends
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'd0,     1'b0, 1'b1, '{16'd0,     1'b0, 7'd0, 1'b0}},
    '{16'd1,     1'b0, 1'b1, '{16'd1,     1'b0, 7'd0, 1'b0}},
    '{16'd2,     1'b0, 1'b1, '{16'd2,     1'b1, 7'd1, 1'b0}},
    '{16'd3,     1'b0, 1'b0, '0},
    '{16'd4,     1'b0, 1'b0, '0},
    '{16'd9,     1'b0, 1'b0, '0},
    '{16'd25,    1'b1, 1'b0, '0},
    '{16'd65535, 1'b0, 1'b1, '{16'd65535, 1'b0, 7'd0, 1'b0}},
    '{16'd65521, 1'b0, 1'b0, '0},
    '{16'd63001, 1'b0, 1'b0, '0},
    '{16'd32768, 1'b0, 1'b0, '0},
    '{16'd21845, 1'b0, 1'b0, '0},
    '{16'd43690, 1'b0, 1'b0, '0},
    '{16'd2,     1'b1, 1'b0, '0},
    '{16'd1,     1'b1, 1'b1, '{16'd1,     1'b0, 7'd0, 1'b1}}
  };

  function automatic bit has_no_divisor(int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_result_t predict_prime_result(
      logic [pftd_pkg::NUMBER_W-1:0] value, logic eol);
    prime_result_t r;
    bit p;
    p = has_no_divisor(32'(value));
    if (p && list_prime_count < COUNT_LIMIT) list_prime_count++;
    r.value = value;
    r.prime = p;
    r.count = list_prime_count[pftd_pkg::COUNT_W-1:0];
    r.done  = eol;
    if (eol) list_prime_count = 0;
    return r;
  endfunction

  function automatic logic [pftd_pkg::NUMBER_W-1:0] pick_value(bit want_prime);
    int unsigned v;
    case ($urandom_range(3))
      0:       v = $urandom_range(255);
      1:       v = $urandom_range(4095);
      default: v = $urandom_range(65535);
    endcase
    if (want_prime) begin
      if (v > 65521) v = 65521;
      while (!has_no_divisor(v)) v++;
    end
    return v[pftd_pkg::NUMBER_W-1:0];
  endfunction

  task automatic send_number(input logic [pftd_pkg::NUMBER_W-1:0] value, input logic eol,
                             input logic typed, input prime_result_t typed_res);
    prime_result_t r;
    in_if.valid       <= 1'b1;
    in_if.number      <= value;
    in_if.end_of_list <= eol;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_prime_result(value, eol);
    result_fifo.push_back(typed ? typed_res : r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk_i);
  endtask

  // result side: scoreboard
  always @(posedge clk_i) begin
    prime_result_t got;
    prime_result_t want;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.tested_value, out_if.is_prime, out_if.primes_so_far, out_if.list_done};
      if (result_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %0d prime %0b count %0d done %0b",
                   got.value, got.prime, got.count, got.done);
      end else begin
        want = result_fifo.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d prime %0b count %0d done %0b, got %0d %0b %0d %0b",
                     want.value, want.prime, want.count, want.done,
                     got.value, got.prime, got.count, got.done);
        end
      end
    end
  end

  // result side: random stalls and long hold-off
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.number      <= '0;
    in_if.end_of_list <= 1'b0;
    list_prime_count  = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_DIRECTED; k++)
      send_number(directed_rows[k].number, directed_rows[k].eol,
                  directed_rows[k].typed, directed_rows[k].res);
    drain_results();

    // receiver holds off while small values keep coming
    @(posedge clk_i);
    hold_request = 1'b1;
    for (k = 0; k < 6; k++)
      send_number(pftd_pkg::NUMBER_W'($urandom_range(255)), k == 5, 1'b0, '0);

    // overlong list of primes to hit count saturation
    for (k = 0; k < 66; k++)
      send_number(pick_value(1'b1), k == 65, 1'b0, '0);
    send_number(16'd2, 1'b1, 1'b0, '0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      sent = 0;
      while (sent < 10) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          send_number(pick_value(bit'($urandom_range(1))), k == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && result_fifo.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
